@@ rtl/cpmt_pkg.sv @@
// Shared types and constants for the periodic CAN message table.
// No dependencies; used by every module under rtl/.
`default_nettype none

package cpmt_pkg;

	localparam int SLOTS  = 5;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int IDX_W  = $clog2(SLOTS + 1);

	localparam int ID_W      = 11;
	localparam int PAYLOAD_W = 64;
	localparam int PERIOD_W  = 16;
	localparam int TIME_W    = 32;
	localparam int CFG_W     = 16;
	localparam int QSLOT_W   = 3;
	localparam int CFG_IDX_W = 8;

	// remainder unit: one quotient bit per cycle
	localparam int MOD_STEPS = PERIOD_W;
	localparam int MOD_CNT_W = $clog2(MOD_STEPS + 1);

	localparam logic [1:0] ACT_UPDATE = 2'd0;
	localparam logic [1:0] ACT_TICK   = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;
	localparam logic [1:0] ACT_NONE   = 2'd3;

	localparam logic [1:0] KIND_ACK    = 2'd0;
	localparam logic [1:0] KIND_FRAME  = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TOP     = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0]    TIMEOUT_RESET = 16'd1000;
	localparam logic [CFG_W-1:0]    TOP_RESET     = 16'd5000;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 16'hFFFF;

	// table write command
	typedef struct packed {
		logic              wr;       // full update of one slot
		logic              restamp;  // stamp only
		logic [SLOT_W-1:0] addr;
	} tbl_cmd_t;

	// remainder unit status
	typedef struct packed {
		logic busy;
		logic done;
		logic zero;
	} mod_res_t;

endpackage

`default_nettype wire

@@ rtl/cpmt_mod.sv @@
// Iterative remainder unit: dividend mod divisor, one bit per cycle.
// Depends on cpmt_pkg.
`default_nettype none

module cpmt_mod (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	input  wire  [cpmt_pkg::PERIOD_W-1:0]       dividend,
	input  wire  [cpmt_pkg::PERIOD_W-1:0]       divisor,
	output cpmt_pkg::mod_res_t                  res
);

	logic [cpmt_pkg::PERIOD_W-1:0]  rem_q;
	logic [cpmt_pkg::PERIOD_W-1:0]  dvd_q;
	logic [cpmt_pkg::PERIOD_W-1:0]  div_q;
	logic [cpmt_pkg::MOD_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [cpmt_pkg::PERIOD_W:0]    trial;
	logic                           fits;

	assign trial = {rem_q, dvd_q[cpmt_pkg::PERIOD_W-1]};
	assign fits  = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= cpmt_pkg::MOD_CNT_W'(cpmt_pkg::MOD_STEPS);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			div_q <= divisor;
		end else if (busy_q && cnt_q != '0) begin
			dvd_q <= {dvd_q[cpmt_pkg::PERIOD_W-2:0], 1'b0};
			if (fits)
				rem_q <= cpmt_pkg::PERIOD_W'(trial - {1'b0, div_q});
			else
				rem_q <= trial[cpmt_pkg::PERIOD_W-1:0];
		end
	end

	assign res.busy = busy_q;
	assign res.done = done_q;
	assign res.zero = (rem_q == '0);

endmodule

`default_nettype wire

@@ rtl/cpmt_table.sv @@
// Slot storage: id, payload, period, stamp and occupancy per slot,
// one read port, id search and write/restamp port. Depends on cpmt_pkg.
`default_nettype none

module cpmt_table (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  cpmt_pkg::tbl_cmd_t                   cmd,
	input  wire  [cpmt_pkg::ID_W-1:0]            wr_id,
	input  wire  [cpmt_pkg::PAYLOAD_W-1:0]       wr_payload,
	input  wire  [cpmt_pkg::PERIOD_W-1:0]        wr_period,
	input  wire  [cpmt_pkg::TIME_W-1:0]          wr_stamp,
	input  wire  [cpmt_pkg::SLOT_W-1:0]          rd_addr,
	output logic                                 rd_used,
	output logic [cpmt_pkg::ID_W-1:0]            rd_id,
	output logic [cpmt_pkg::PAYLOAD_W-1:0]       rd_payload,
	output logic [cpmt_pkg::PERIOD_W-1:0]        rd_period,
	output logic [cpmt_pkg::TIME_W-1:0]          rd_stamp,
	output logic                                 srch_hit,
	output logic [cpmt_pkg::SLOT_W-1:0]          srch_idx
);

	logic [cpmt_pkg::SLOTS-1:0]           used_q;
	logic [cpmt_pkg::ID_W-1:0]            id_q      [cpmt_pkg::SLOTS];
	logic [cpmt_pkg::PAYLOAD_W-1:0]       payload_q [cpmt_pkg::SLOTS];
	logic [cpmt_pkg::PERIOD_W-1:0]        period_q  [cpmt_pkg::SLOTS];
	logic [cpmt_pkg::TIME_W-1:0]          stamp_q   [cpmt_pkg::SLOTS];

	logic                        m_found;
	logic                        f_found;
	logic [cpmt_pkg::SLOT_W-1:0] m_idx;
	logic [cpmt_pkg::SLOT_W-1:0] f_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			for (int i = 0; i < cpmt_pkg::SLOTS; i++) begin
				id_q[i]      <= '0;
				payload_q[i] <= '0;
				period_q[i]  <= cpmt_pkg::PERIOD_RESET;
				stamp_q[i]   <= '0;
			end
		end else if (cmd.wr) begin
			used_q[cmd.addr]    <= 1'b1;
			id_q[cmd.addr]      <= wr_id;
			payload_q[cmd.addr] <= wr_payload;
			period_q[cmd.addr]  <= wr_period;
			stamp_q[cmd.addr]   <= wr_stamp;
		end else if (cmd.restamp) begin
			stamp_q[cmd.addr] <= wr_stamp;
		end
	end

	assign rd_used    = used_q[rd_addr];
	assign rd_id      = id_q[rd_addr];
	assign rd_payload = payload_q[rd_addr];
	assign rd_period  = period_q[rd_addr];
	assign rd_stamp   = stamp_q[rd_addr];

	// lowest slot holding the id, else lowest free slot
	always_comb begin
		m_found = 1'b0;
		f_found = 1'b0;
		m_idx   = '0;
		f_idx   = '0;
		for (int i = 0; i < cpmt_pkg::SLOTS; i++) begin
			if (!m_found && used_q[i] && id_q[i] == wr_id) begin
				m_found = 1'b1;
				m_idx   = cpmt_pkg::SLOT_W'(i);
			end
			if (!f_found && !used_q[i]) begin
				f_found = 1'b1;
				f_idx   = cpmt_pkg::SLOT_W'(i);
			end
		end
	end

	assign srch_hit = m_found | f_found;
	assign srch_idx = m_found ? m_idx : f_idx;

endmodule

`default_nettype wire

@@ rtl/can_periodic_message_table.sv @@
// Top level of the periodic CAN message table: sequencer, config registers,
// output register. Depends on cpmt_pkg, cpmt_table and cpmt_mod.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+----------------------------------------
//  s_*     | in  | s_tvalid / s_tready    | tuser action, tdata update/tick/query
//  m_*     | out | m_tvalid / m_tready    | tuser kind, tdata slot result, tlast
//  cfg_*   | in  | cfg_valid / cfg_ready  | cfg_index register, cfg_data value
//
// Sequence: an update passes through S_UPD and a query through S_QRY; a tick goes
// through S_TCNT, then S_SCAN per slot, S_MOD for a used slot with non-zero period
// (the 16-step remainder unit), S_HIT per hit and S_TEND to close the walk.
// The shared bit-serial remainder unit dominates the length of a tick.
// Reset clears occupancy, tick counter and table contents (periods load all ones),
// and loads the config defaults. s_tready is high only while the sequencer is idle;
// the output register takes a result only when empty, so a stalled m_tready holds
// the sequencer at its next result. Config writes are taken in every cycle.
`default_nettype none

module can_periodic_message_table (
	input  wire          clk,
	input  wire          arst_n,
	// input stream
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [1:0]   s_tuser,   // [1:0] action
	input  wire  [127:0] s_tdata,   // [10:0] msg_id, [74:11] msg_payload,
	                                // [90:75] send_period, [122:91] now_ms,
	                                // [125:123] query_slot, rest zero
	// result stream
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [1:0]   m_tuser,   // [1:0] kind
	output logic [87:0]  m_tdata,   // [2:0] slot, [3] stored, [14:4] out_id,
	                                // [78:15] out_payload, [79] occupied,
	                                // [80] fresh, rest zero
	output logic         m_tlast,
	// config writes
	input  wire          cfg_valid,
	output logic         cfg_ready,
	input  wire  [7:0]   cfg_index,
	input  wire  [15:0]  cfg_data
);

	// sequencer codes
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_UPD  = 3'd1;
	localparam logic [2:0] S_TCNT = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_MOD  = 3'd4;
	localparam logic [2:0] S_HIT  = 3'd5;
	localparam logic [2:0] S_TEND = 3'd6;
	localparam logic [2:0] S_QRY  = 3'd7;

	logic [2:0] state_q;

	// config
	logic [cpmt_pkg::CFG_W-1:0] timeout_q;
	logic [cpmt_pkg::CFG_W-1:0] top_q;

	// latched input item
	logic [cpmt_pkg::ID_W-1:0]      id_q;
	logic [cpmt_pkg::PAYLOAD_W-1:0] payload_q;
	logic [cpmt_pkg::PERIOD_W-1:0]  period_q;
	logic [cpmt_pkg::TIME_W-1:0]    now_q;
	logic [cpmt_pkg::QSLOT_W-1:0]   qslot_q;

	// tick walk
	logic [cpmt_pkg::PERIOD_W-1:0]  tick_q;
	logic [cpmt_pkg::IDX_W-1:0]     idx_q;
	logic [cpmt_pkg::PERIOD_W:0]    tick_inc;

	// held frame, sent once the next hit or the end of the walk sets tlast
	logic                           pend_v_q;
	logic [cpmt_pkg::SLOT_W-1:0]    pend_slot_q;
	logic [cpmt_pkg::ID_W-1:0]      pend_id_q;
	logic [cpmt_pkg::PAYLOAD_W-1:0] pend_payload_q;

	// output register
	logic                           out_valid_q;
	logic [1:0]                     out_kind_q;
	logic [2:0]                     out_slot_q;
	logic                           out_stored_q;
	logic [cpmt_pkg::ID_W-1:0]      out_id_q;
	logic [cpmt_pkg::PAYLOAD_W-1:0] out_payload_q;
	logic                           out_occ_q;
	logic                           out_fresh_q;
	logic                           out_last_q;

	// next result
	logic                           push;
	logic [1:0]                     push_kind;
	logic [2:0]                     push_slot;
	logic                           push_stored;
	logic [cpmt_pkg::ID_W-1:0]      push_id;
	logic [cpmt_pkg::PAYLOAD_W-1:0] push_payload;
	logic                           push_occ;
	logic                           push_fresh;
	logic                           push_last;

	// table and remainder unit
	cpmt_pkg::tbl_cmd_t             tbl_cmd;
	logic [cpmt_pkg::SLOT_W-1:0]    rd_addr;
	logic                           rd_used;
	logic [cpmt_pkg::ID_W-1:0]      rd_id;
	logic [cpmt_pkg::PAYLOAD_W-1:0] rd_payload;
	logic [cpmt_pkg::PERIOD_W-1:0]  rd_period;
	logic [cpmt_pkg::TIME_W-1:0]    rd_stamp;
	logic                           srch_hit;
	logic [cpmt_pkg::SLOT_W-1:0]    srch_idx;
	logic                           mod_start;
	cpmt_pkg::mod_res_t             mod_res;

	logic                           in_xfer;
	logic                           out_free;
	logic                           walk_end;
	logic                           q_in_range;
	logic [cpmt_pkg::TIME_W-1:0]    age;
	logic                           q_fresh;

	assign s_tready  = (state_q == S_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q;
	assign walk_end  = (idx_q == cpmt_pkg::IDX_W'(cpmt_pkg::SLOTS));
	assign q_in_range = (32'(qslot_q) < 32'(cpmt_pkg::SLOTS));
	assign age       = now_q - rd_stamp;
	assign q_fresh   = rd_used && (age <= {16'd0, timeout_q});
	assign tick_inc  = {1'b0, tick_q} + 1'b1;

	// query reads the asked slot, the walk reads its own index
	assign rd_addr = (state_q == S_QRY) ? cpmt_pkg::SLOT_W'(qslot_q)
	                                    : idx_q[cpmt_pkg::SLOT_W-1:0];

	assign mod_start = (state_q == S_SCAN) && !walk_end && rd_used && rd_period != '0;

	cpmt_table u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (tbl_cmd),
		.wr_id      (id_q),
		.wr_payload (payload_q),
		.wr_period  (period_q),
		.wr_stamp   (now_q),
		.rd_addr    (rd_addr),
		.rd_used    (rd_used),
		.rd_id      (rd_id),
		.rd_payload (rd_payload),
		.rd_period  (rd_period),
		.rd_stamp   (rd_stamp),
		.srch_hit   (srch_hit),
		.srch_idx   (srch_idx)
	);

	cpmt_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (tick_q),
		.divisor  (rd_period),
		.res      (mod_res)
	);

	// result selection and table commands
	always_comb begin
		push         = 1'b0;
		push_kind    = cpmt_pkg::KIND_ACK;
		push_slot    = '0;
		push_stored  = 1'b0;
		push_id      = '0;
		push_payload = '0;
		push_occ     = 1'b0;
		push_fresh   = 1'b0;
		push_last    = 1'b1;
		tbl_cmd      = '0;
		unique case (state_q)
			S_UPD: begin
				if (out_free) begin
					push = 1'b1;
					if (srch_hit) begin
						tbl_cmd.wr    = 1'b1;
						tbl_cmd.addr  = srch_idx;
						push_slot     = 3'(srch_idx);
						push_stored   = 1'b1;
						push_id       = id_q;
						push_payload  = payload_q;
						push_occ      = 1'b1;
						push_fresh    = 1'b1;
					end
				end
			end
			S_HIT: begin
				if (!pend_v_q || out_free) begin
					tbl_cmd.restamp = 1'b1;
					tbl_cmd.addr    = idx_q[cpmt_pkg::SLOT_W-1:0];
					push            = pend_v_q;
					push_kind       = cpmt_pkg::KIND_FRAME;
					push_slot       = 3'(pend_slot_q);
					push_id         = pend_id_q;
					push_payload    = pend_payload_q;
					push_occ        = 1'b1;
					push_fresh      = 1'b1;
					push_last       = 1'b0;
				end
			end
			S_TEND: begin
				push         = pend_v_q && out_free;
				push_kind    = cpmt_pkg::KIND_FRAME;
				push_slot    = 3'(pend_slot_q);
				push_id      = pend_id_q;
				push_payload = pend_payload_q;
				push_occ     = 1'b1;
				push_fresh   = 1'b1;
			end
			S_QRY: begin
				push      = out_free;
				push_kind = cpmt_pkg::KIND_STATUS;
				push_slot = qslot_q;
				if (q_in_range) begin
					push_id      = rd_id;
					push_payload = rd_payload;
					push_occ     = rd_used;
					push_fresh   = q_fresh;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			tick_q   <= '0;
			idx_q    <= '0;
			pend_v_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						unique case (s_tuser)
							cpmt_pkg::ACT_UPDATE: state_q <= S_UPD;
							cpmt_pkg::ACT_TICK:   state_q <= S_TCNT;
							cpmt_pkg::ACT_QUERY:  state_q <= S_QRY;
							cpmt_pkg::ACT_NONE:   state_q <= S_IDLE;
						endcase
					end
				end
				S_UPD, S_QRY: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				S_TCNT: begin
					// wrap to one once past the top (also when top was lowered)
					if (tick_inc > {1'b0, top_q})
						tick_q <= cpmt_pkg::PERIOD_W'(1);
					else
						tick_q <= tick_inc[cpmt_pkg::PERIOD_W-1:0];
					idx_q    <= '0;
					pend_v_q <= 1'b0;
					state_q  <= S_SCAN;
				end
				S_SCAN: begin
					if (walk_end)
						state_q <= S_TEND;
					else if (mod_start)
						state_q <= S_MOD;
					else
						idx_q <= idx_q + 1'b1;
				end
				S_MOD: begin
					if (mod_res.done) begin
						if (mod_res.zero) begin
							state_q <= S_HIT;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_SCAN;
						end
					end
				end
				S_HIT: begin
					if (!pend_v_q || out_free) begin
						pend_v_q <= 1'b1;
						idx_q    <= idx_q + 1'b1;
						state_q  <= S_SCAN;
					end
				end
				S_TEND: begin
					if (!pend_v_q || out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item latch and held frame, no reset needed
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			id_q      <= s_tdata[10:0];
			payload_q <= s_tdata[74:11];
			period_q  <= s_tdata[90:75];
			now_q     <= s_tdata[122:91];
			qslot_q   <= s_tdata[125:123];
		end
		if (state_q == S_HIT && (!pend_v_q || out_free)) begin
			pend_slot_q    <= idx_q[cpmt_pkg::SLOT_W-1:0];
			pend_id_q      <= rd_id;
			pend_payload_q <= rd_payload;
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= cpmt_pkg::TIMEOUT_RESET;
			top_q     <= cpmt_pkg::TOP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == cpmt_pkg::REG_TIMEOUT)
				timeout_q <= cfg_data;
			else if (cfg_index == cpmt_pkg::REG_TOP)
				top_q <= cfg_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_kind_q    <= push_kind;
			out_slot_q    <= push_slot;
			out_stored_q  <= push_stored;
			out_id_q      <= push_id;
			out_payload_q <= push_payload;
			out_occ_q     <= push_occ;
			out_fresh_q   <= push_fresh;
			out_last_q    <= push_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {7'd0, out_fresh_q, out_occ_q, out_payload_q, out_id_q,
	                   out_stored_q, out_slot_q};

`ifndef SYNTH
	// remainder result only arrives while the walk waits for it
	a_mod_done_in_mod: assert property (@(posedge clk) disable iff (!arst_n)
		mod_res.done |-> state_q == S_MOD)
		else $error("remainder done outside wait state");

	// the unit is never busy while the block takes items
	a_mod_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !mod_res.busy)
		else $error("remainder unit busy while idle");

	// tick counter never zero once a walk is under way
	a_tick_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> tick_q != '0)
		else $error("tick counter zero during walk");

	// a held frame always belongs to a slot already walked past
	a_pend_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_v_q && state_q == S_SCAN) |->
		cpmt_pkg::IDX_W'(pend_slot_q) < idx_q)
		else $error("held frame ahead of walk index");
`endif

endmodule

`default_nettype wire

@@ tb/can_periodic_message_table_test.sv @@
// Self-checking testbench for the periodic CAN message table: directed and random
// update, tick and query traffic, with a built-in table predictor and result checker.
// Depends on cpmt_pkg and can_periodic_message_table.
`default_nettype none

module can_periodic_message_table_test;
	import cpmt_pkg::*;

	// one result as the block should present it
	typedef struct packed {
		logic [1:0]           kind;
		logic [QSLOT_W-1:0]   slot;
		logic                 stored;
		logic [ID_W-1:0]      id;
		logic [PAYLOAD_W-1:0] payload;
		logic                 occupied;
		logic                 fresh;
		logic                 last;
	} slot_result_t;

	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	logic [1:0]   s_tuser   = ACT_NONE;
	logic [127:0] s_tdata   = '0;
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	logic [1:0]   m_tuser;
	logic [87:0]  m_tdata;
	logic         m_tlast;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [7:0]   cfg_index = '0;
	logic [15:0]  cfg_data  = '0;

	can_periodic_message_table DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tuser   (m_tuser),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predicted table contents and registers
	logic                 tbl_used    [SLOTS];
	logic [ID_W-1:0]      tbl_id      [SLOTS];
	logic [PAYLOAD_W-1:0] tbl_payload [SLOTS];
	logic [PERIOD_W-1:0]  tbl_period  [SLOTS];
	logic [TIME_W-1:0]    tbl_stamp   [SLOTS];
	logic [PERIOD_W-1:0]  tick_count_now = '0;
	logic [CFG_W-1:0]     cfg_timeout    = TIMEOUT_RESET;
	logic [CFG_W-1:0]     cfg_top        = TOP_RESET;

	slot_result_t results_due[$];

	bit          idle_on   = 1'b1;
	int          hold_len  = 0;
	int          hold_asks = 0;
	int          mismatches = 0;
	int          n_updates = 0, n_ticks = 0, n_queries = 0, n_noops = 0;
	int          n_checked = 0, n_frames = 0, n_dropped = 0;
	logic [31:0] wall_ms = 32'hFFFF_F000;

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			tbl_used[i]    = 1'b0;
			tbl_id[i]      = '0;
			tbl_payload[i] = '0;
			tbl_period[i]  = PERIOD_RESET;
			tbl_stamp[i]   = '0;
		end
	end

	// Work out what one accepted transfer does to the table and queue its results.
	function automatic void table_apply(input logic [1:0] act, input logic [ID_W-1:0] id,
			input logic [PAYLOAD_W-1:0] data, input logic [PERIOD_W-1:0] period,
			input logic [TIME_W-1:0] now, input logic [QSLOT_W-1:0] q);
		int               pos;
		int               last_hit;
		logic [PERIOD_W:0] c;
		logic [TIME_W-1:0] age;
		slot_result_t     r;
		pos = -1;
		last_hit = -1;
		r = '0;
		case (act)
			ACT_UPDATE: begin
				n_updates++;
				for (int i = 0; i < SLOTS; i++)
					if (pos < 0 && tbl_used[i] && tbl_id[i] == id)
						pos = i;
				for (int i = 0; i < SLOTS; i++)
					if (pos < 0 && !tbl_used[i])
						pos = i;
				r.kind = KIND_ACK;
				r.last = 1'b1;
				if (pos < 0) begin
					n_dropped++;
				end else begin
					tbl_used[pos]    = 1'b1;
					tbl_id[pos]      = id;
					tbl_payload[pos] = data;
					tbl_period[pos]  = period;
					tbl_stamp[pos]   = now;
					r.slot     = QSLOT_W'(pos);
					r.stored   = 1'b1;
					r.id       = id;
					r.payload  = data;
					r.occupied = 1'b1;
					r.fresh    = 1'b1;
				end
				results_due.push_back(r);
			end
			ACT_TICK: begin
				n_ticks++;
				c = {1'b0, tick_count_now} + 1'b1;
				if (c > {1'b0, cfg_top})
					c = (PERIOD_W + 1)'(1);
				tick_count_now = c[PERIOD_W-1:0];
				for (int i = 0; i < SLOTS; i++)
					if (tbl_used[i] && tbl_period[i] != 0 && c % {1'b0, tbl_period[i]} == 0)
						last_hit = i;
				for (int i = 0; i < SLOTS; i++) begin
					if (tbl_used[i] && tbl_period[i] != 0 && c % {1'b0, tbl_period[i]} == 0) begin
						tbl_stamp[i] = now;
						r = '0;
						r.kind     = KIND_FRAME;
						r.slot     = QSLOT_W'(i);
						r.id       = tbl_id[i];
						r.payload  = tbl_payload[i];
						r.occupied = 1'b1;
						r.fresh    = 1'b1;
						r.last     = (i == last_hit);
						results_due.push_back(r);
					end
				end
			end
			ACT_QUERY: begin
				n_queries++;
				r.kind = KIND_STATUS;
				r.slot = q;
				r.last = 1'b1;
				if (q < SLOTS) begin
					age        = now - tbl_stamp[q];
					r.id       = tbl_id[q];
					r.payload  = tbl_payload[q];
					r.occupied = tbl_used[q];
					r.fresh    = tbl_used[q] && age <= TIME_W'(cfg_timeout);
				end
				results_due.push_back(r);
			end
			default: n_noops++;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		$display("MISMATCH @%0t %s: got %h want %h", $time, what, got, want);
	endtask

	// result side: random back-pressure plus long holds on request
	always @(posedge clk) begin : result_sink
		int hold_seen;
		int hold_left;
		if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = hold_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(idle_on && $urandom_range(99) < 28);
		end
	end

	// compare every result transfer with the oldest prediction
	always @(posedge clk) begin : result_check
		slot_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				report_mismatch("result with nothing pending", m_tdata[63:0], '0);
			end else begin
				want = results_due.pop_front();
				n_checked++;
				if (want.kind == KIND_FRAME)
					n_frames++;
				if (m_tuser !== want.kind)
					report_mismatch("kind", 64'(m_tuser), 64'(want.kind));
				if (m_tdata[2:0] !== want.slot)
					report_mismatch("slot", 64'(m_tdata[2:0]), 64'(want.slot));
				if (m_tdata[3] !== want.stored)
					report_mismatch("stored", 64'(m_tdata[3]), 64'(want.stored));
				if (m_tdata[14:4] !== want.id)
					report_mismatch("out_id", 64'(m_tdata[14:4]), 64'(want.id));
				if (m_tdata[78:15] !== want.payload)
					report_mismatch("out_payload", m_tdata[78:15], want.payload);
				if (m_tdata[79] !== want.occupied)
					report_mismatch("occupied", 64'(m_tdata[79]), 64'(want.occupied));
				if (m_tdata[80] !== want.fresh)
					report_mismatch("fresh", 64'(m_tdata[80]), 64'(want.fresh));
				if (m_tdata[87:81] !== '0)
					report_mismatch("tdata padding", 64'(m_tdata[87:81]), '0);
				if (m_tlast !== want.last)
					report_mismatch("tlast", 64'(m_tlast), 64'(want.last));
			end
		end
	end

	// one input transfer; tvalid is left high so back-to-back items need no gap
	task automatic send_item(input logic [1:0] act, input logic [ID_W-1:0] id,
			input logic [PAYLOAD_W-1:0] data, input logic [PERIOD_W-1:0] period,
			input logic [TIME_W-1:0] now, input logic [QSLOT_W-1:0] q);
		while (idle_on && $urandom_range(99) < 28) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {2'b00, q, now, period, data, id};
		do @(posedge clk); while (!s_tready);
		table_apply(act, id, data, period, now, q);
	endtask

	// unused fields carry junk so that the block is seen to ignore them
	task automatic do_update(input logic [ID_W-1:0] id, input logic [PAYLOAD_W-1:0] data,
			input logic [PERIOD_W-1:0] period, input logic [TIME_W-1:0] now);
		send_item(ACT_UPDATE, id, data, period, now, QSLOT_W'($urandom));
	endtask

	task automatic do_tick(input logic [TIME_W-1:0] now);
		send_item(ACT_TICK, ID_W'($urandom), {$urandom, $urandom}, PERIOD_W'($urandom),
			now, QSLOT_W'($urandom));
	endtask

	task automatic do_query(input logic [QSLOT_W-1:0] q, input logic [TIME_W-1:0] now);
		send_item(ACT_QUERY, ID_W'($urandom), {$urandom, $urandom}, PERIOD_W'($urandom),
			now, q);
	endtask

	task automatic do_noop();
		send_item(ACT_NONE, ID_W'($urandom), {$urandom, $urandom}, PERIOD_W'($urandom),
			$urandom, QSLOT_W'($urandom));
	endtask

	// millisecond clock for random traffic, with the odd fully random time
	function automatic logic [TIME_W-1:0] next_time();
		wall_ms += $urandom_range(0, 300);
		return ($urandom_range(9) == 0) ? TIME_W'($urandom) : wall_ms;
	endfunction

	// stop sending and let the block drain, incl. ticks that give no result
	task automatic settle();
		s_tvalid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	// both registers, then a write to an unused index that must be ignored
	task automatic set_registers(input logic [CFG_W-1:0] timeout, input logic [CFG_W-1:0] top);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= REG_TIMEOUT;
		cfg_data  <= timeout;
		do @(posedge clk); while (!cfg_ready);
		cfg_timeout = timeout;
		cfg_index <= REG_TOP;
		cfg_data  <= top;
		do @(posedge clk); while (!cfg_ready);
		cfg_top = top;
		cfg_index <= 8'($urandom_range(2, 255));
		cfg_data  <= 16'($urandom);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_empty_table();
		do_query(QSLOT_W'(0), $urandom);
		do_query(QSLOT_W'(SLOTS - 1), $urandom);
		do_query(3'd7, $urandom);    // beyond the table
		do_tick(32'h0);              // nothing to send
		do_noop();
	endtask

	task automatic test_fill_and_drop();
		do_update(11'h000, 64'h0, 16'd1, 32'hFFFF_FFF0);
		do_update(11'h7FF, '1, 16'hFFFF, 32'h0000_0010);
		do_update(11'h155, {$urandom, $urandom}, 16'd0, 32'hFFFF_FF00);  // never sends
		do_update(11'h7FF, {$urandom, $urandom}, 16'd3, 32'h0000_0020);  // rewrite by id
		do_update(11'h2AA, {$urandom, $urandom}, 16'd2, 32'h0000_0030);
		do_update(11'h123, {$urandom, $urandom}, 16'd1, 32'h0000_0040);
		do_update(11'h456, {$urandom, $urandom}, 16'd5, 32'h0000_0050);  // table full
		do_tick(32'h0000_0060);
		do_tick(32'h0000_0070);
	endtask

	// ages right at and just past the timeout, with stamps that wrap
	task automatic test_freshness_edges();
		do_query(QSLOT_W'(2), tbl_stamp[2] + TIME_W'(cfg_timeout));
		do_query(QSLOT_W'(2), tbl_stamp[2] + TIME_W'(cfg_timeout) + 32'd1);
		set_registers(16'd0, cfg_top);
		do_query(QSLOT_W'(2), tbl_stamp[2]);
		do_query(QSLOT_W'(2), tbl_stamp[2] + 32'd1);
		set_registers(16'hFFFF, cfg_top);
		do_query(QSLOT_W'(2), tbl_stamp[2] + 32'd65535);
		do_query(QSLOT_W'(2), tbl_stamp[2] + 32'd65536);
	endtask

	task automatic test_tick_wrap();
		set_registers(TIMEOUT_RESET, 16'd0);
		do_tick(next_time());
		set_registers(TIMEOUT_RESET, 16'd50);
		repeat (4) do_tick(next_time());
		set_registers(TIMEOUT_RESET, 16'd2);   // top now below the count
		do_tick(next_time());
	endtask

	// every slot sends on every tick while the result side is held off
	task automatic test_backpressure();
		set_registers(TIMEOUT_RESET, 16'd60);
		for (int i = 0; i < SLOTS; i++)
			do_update(tbl_id[i], {$urandom, $urandom}, 16'd1, next_time());
		hold_len = 400;
		hold_asks++;
		repeat (8) do_tick(next_time());
		settle();
		do_query(QSLOT_W'($urandom_range(0, SLOTS - 1)), next_time());
	endtask

	task automatic test_random_traffic(input int count, input bit no_idle);
		int          pick;
		int          done;
		logic [2:0]  q;
		logic [15:0] period;
		done = 0;
		idle_on = !no_idle;
		while (done < count) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				period = ($urandom_range(99) < 60) ? 16'($urandom_range(1, 4)) :
					($urandom_range(99) < 40) ? 16'd0 : 16'($urandom);
				do_update(($urandom_range(9) < 8) ? tbl_id[$urandom_range(SLOTS - 1)] :
					ID_W'($urandom), {$urandom, $urandom}, period, next_time());
				done++;
			end else if (pick < 70) begin
				do_tick(next_time());
				done++;
			end else if (pick < 95) begin
				q = ($urandom_range(9) < 8) ? 3'($urandom_range(0, SLOTS - 1)) :
					3'($urandom_range(SLOTS, 7));
				if (q < SLOTS && $urandom_range(1) == 1)
					do_query(q, tbl_stamp[q] + TIME_W'(cfg_timeout) +
						TIME_W'($urandom_range(0, 2)) - 32'd1);
				else
					do_query(q, next_time());
				done++;
			end else begin
				do_noop();
			end
		end
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_fill_and_drop();
		test_freshness_edges();
		test_tick_wrap();
		test_backpressure();

		set_registers(TIMEOUT_RESET, 16'd12);
		test_random_traffic(95, 1'b0);
		set_registers(16'($urandom), 16'd6);
		test_random_traffic(85, 1'b1);        // long stretch with no gaps
		set_registers(16'($urandom_range(0, 40)), 16'd1);
		test_random_traffic(75, 1'b0);
		set_registers(16'hFFFF, 16'hFFFF);
		test_random_traffic(65, 1'b0);
		set_registers(16'($urandom), 16'($urandom_range(0, 40)));
		test_random_traffic(85, 1'b0);

		settle();
		$display("Covered %0d updates (%0d dropped), %0d ticks, %0d queries, %0d ignored actions",
			n_updates, n_dropped, n_ticks, n_queries, n_noops);
		$display("Checked %0d results, %0d of them frames; %0d mismatches",
			n_checked, n_frames, mismatches);
		if (mismatches == 0)
			$display("can_periodic_message_table test passed");
		else
			$display("can_periodic_message_table test failed");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Timeout with %0d results still pending", results_due.size());
		$display("can_periodic_message_table test failed");
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/cpmt_pkg.sv
rtl/cpmt_mod.sv
rtl/cpmt_table.sv
rtl/can_periodic_message_table.sv
tb/can_periodic_message_table_test.sv
